@@ hw/rtl/hdkd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdkd_pkg: shared types and constants of the duplicate key detector
// Key field widths, hash mixing constants, status codes and the command and
// status records that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package hdkd_pkg;

	localparam int TABLE_SLOTS_DEF = 64;

	localparam int OWN_W  = 64;
	localparam int SLOT_W = 32;
	localparam int GEN_W  = 32;
	localparam int REV_W  = 64;
	localparam int HASH_W = 64;

	localparam int SLOT_SHIFT = 32;
	localparam int GEN_SHIFT  = 1;
	localparam int MIX_SHIFT  = 33;
	localparam logic [HASH_W-1:0] MIX_MULT = 64'hff51afd7ed558ccd;

	// Width of the set tag kept with every table entry.
	localparam int EPOCH_W = 8;

	typedef enum logic [1:0] {
		ST_INSERTED  = 2'd0,
		ST_DUPLICATE = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		MUL_LL = 2'd0,
		MUL_LH = 2'd1,
		MUL_HL = 2'd2
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     clr_wr;
		logic     epoch_inc;
		logic     epoch_reset;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     idx_load;
		logic     idx_step;
		logic     rd_en;
		logic     ins_wr;
		logic     finish;
		status_t  code;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic epoch_max;
		logic slot_free;
		logic key_match;
		logic probe_last;
	} dp_sts_t;

endpackage

@@ hw/rtl/hdkd_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdkd_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hdkd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/hdkd_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdkd_datapath: key registers, hash unit and probe table
// Folds and mixes the key with one shared 32x32 multiplier, walks the table
// by linear probing and keeps the set tag that marks live entries.
// ----------------------------------------------------------------------------
module hdkd_datapath #(
	parameter int TABLE_SLOTS = hdkd_pkg::TABLE_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hdkd_pkg::dp_cmd_t             cmd,
	output hdkd_pkg::dp_sts_t             sts,
	input  logic [hdkd_pkg::OWN_W-1:0]    canvas_ownership,
	input  logic [hdkd_pkg::SLOT_W-1:0]   canvas_slot,
	input  logic [hdkd_pkg::GEN_W-1:0]    canvas_generation,
	input  logic [hdkd_pkg::REV_W-1:0]    revision_key,
	output logic [1:0]                    status,
	output logic                          done
);

	import hdkd_pkg::*;

	localparam int IDX_W   = $clog2(TABLE_SLOTS);
	localparam int KEY_W   = OWN_W + SLOT_W + GEN_W + REV_W;
	localparam int ENTRY_W = EPOCH_W + KEY_W;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_SLOTS - 1);

	logic [OWN_W-1:0]   own_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [GEN_W-1:0]   gen_q;
	logic [REV_W-1:0]   rev_q;
	logic [HASH_W-1:0]  mix_q;
	logic [HASH_W-1:0]  acc_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   probe_q;
	logic [IDX_W-1:0]   clr_q;
	logic [EPOCH_W-1:0] epoch_q;
	status_t            status_q;
	logic               done_q;

	logic [HASH_W-1:0]  fold_in;
	logic [HASH_W-1:0]  mix_in;
	logic [31:0]        mul_a;
	logic [31:0]        mul_b;
	logic [63:0]        mul_p;
	logic [HASH_W-1:0]  hash_h;
	logic [KEY_W-1:0]   key_q;
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;
	logic [EPOCH_W-1:0] rd_epoch;
	logic [KEY_W-1:0]   rd_key;

	assign fold_in = canvas_ownership
		^ ({32'b0, canvas_slot} << SLOT_SHIFT)
		^ ({32'b0, canvas_generation} << GEN_SHIFT)
		^ revision_key;
	assign mix_in = fold_in ^ (fold_in >> MIX_SHIFT);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			own_q  <= canvas_ownership;
			slot_q <= canvas_slot;
			gen_q  <= canvas_generation;
			rev_q  <= revision_key;
			mix_q  <= mix_in;
		end
	end

	// The product is needed modulo 2^64 only, so the high-by-high partial
	// product drops out and only three 32x32 products are summed.
	always_comb begin
		case (cmd.mul_sel)
			MUL_LL: begin
				mul_a = mix_q[31:0];
				mul_b = MIX_MULT[31:0];
			end
			MUL_LH: begin
				mul_a = mix_q[31:0];
				mul_b = MIX_MULT[63:32];
			end
			MUL_HL: begin
				mul_a = mix_q[63:32];
				mul_b = MIX_MULT[31:0];
			end
			default: begin
				mul_a = mix_q[31:0];
				mul_b = MIX_MULT[31:0];
			end
		endcase
	end

	assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			if (cmd.mul_sel == MUL_LL) begin
				acc_q <= mul_p;
			end else begin
				acc_q <= acc_q + {mul_p[31:0], 32'b0};
			end
		end
	end

	assign hash_h = acc_q ^ (acc_q >> MIX_SHIFT);

	always_ff @(posedge clk) begin
		if (cmd.idx_load) begin
			idx_q   <= hash_h[IDX_W-1:0];
			probe_q <= '0;
		end else if (cmd.idx_step) begin
			idx_q   <= idx_q + 1'b1;
			probe_q <= probe_q + 1'b1;
		end
	end

	// An entry is live only when its tag equals the current set tag; tag zero
	// is never current, so a clearing pass writes zero everywhere.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			epoch_q <= EPOCH_W'(1);
			done_q  <= 1'b0;
		end else begin
			if (cmd.clr_wr) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.epoch_reset) begin
				epoch_q <= EPOCH_W'(1);
			end else if (cmd.epoch_inc) begin
				epoch_q <= epoch_q + 1'b1;
			end
			done_q <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status_q <= cmd.code;
		end
	end

	assign key_q     = {own_q, slot_q, gen_q, rev_q};
	assign ram_we    = cmd.clr_wr | cmd.ins_wr;
	assign ram_waddr = cmd.clr_wr ? clr_q : idx_q;
	assign ram_wdata = cmd.clr_wr ? '0 : {epoch_q, key_q};

	hdkd_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_SLOTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd_en),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	assign rd_epoch = ram_rdata[ENTRY_W-1 -: EPOCH_W];
	assign rd_key   = ram_rdata[KEY_W-1:0];

	assign sts.clr_last   = (clr_q == IDX_LAST);
	assign sts.epoch_max  = &epoch_q;
	assign sts.slot_free  = (rd_epoch != epoch_q);
	assign sts.key_match  = (rd_key == key_q);
	assign sts.probe_last = (probe_q == IDX_LAST);

	assign status = status_q;
	assign done   = done_q;

endmodule

@@ hw/rtl/hdkd_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdkd_ctrl: sequencing state machine
// Runs the clearing pass, the three multiply steps of the hash and the
// read and compare loop of the probe walk.
// ----------------------------------------------------------------------------
module hdkd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              start_new_set,
	input  hdkd_pkg::dp_sts_t sts,
	output hdkd_pkg::dp_cmd_t cmd,
	output logic              busy
);

	import hdkd_pkg::*;

	typedef enum logic [7:0] {
		S_CLEAR = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_MUL0  = 8'b0000_0100,
		S_MUL1  = 8'b0000_1000,
		S_MUL2  = 8'b0001_0000,
		S_HASH  = 8'b0010_0000,
		S_READ  = 8'b0100_0000,
		S_CMP   = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   pend_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					cmd.epoch_reset = 1'b1;
					state_nxt       = pend_q ? S_MUL0 : S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					// Running out of set tags forces a full sweep of the table.
					if (start_new_set && sts.epoch_max) begin
						state_nxt = S_CLEAR;
					end else begin
						cmd.epoch_inc = start_new_set;
						state_nxt     = S_MUL0;
					end
				end
			end
			S_MUL0: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_LL;
				state_nxt   = S_MUL1;
			end
			S_MUL1: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_LH;
				state_nxt   = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_HL;
				state_nxt   = S_HASH;
			end
			S_HASH: begin
				cmd.idx_load = 1'b1;
				state_nxt    = S_READ;
			end
			S_READ: begin
				cmd.rd_en = 1'b1;
				state_nxt = S_CMP;
			end
			S_CMP: begin
				if (sts.slot_free) begin
					cmd.ins_wr = 1'b1;
					cmd.finish = 1'b1;
					cmd.code   = ST_INSERTED;
					state_nxt  = S_IDLE;
				end else if (sts.key_match) begin
					cmd.finish = 1'b1;
					cmd.code   = ST_DUPLICATE;
					state_nxt  = S_IDLE;
				end else if (sts.probe_last) begin
					cmd.finish = 1'b1;
					cmd.code   = ST_FULL;
					state_nxt  = S_IDLE;
				end else begin
					cmd.idx_step = 1'b1;
					state_nxt    = S_READ;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == S_IDLE && start) begin
				pend_q <= 1'b1;
			end else if (state_q == S_CLEAR && sts.clr_last) begin
				pend_q <= 1'b0;
			end
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

@@ hw/rtl/hashed_duplicate_key_detector.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_duplicate_key_detector: duplicate key check over a hash table
// Inserts each key into an open-addressing table with linear probing and
// reports inserted, duplicate or table full.
// ----------------------------------------------------------------------------
// Sequence: from the accepting edge the shared 32x32 multiplier runs through
// S_MUL0, S_MUL1 and S_MUL2, S_HASH loads the index, and each probe of the walk
// then takes a table read and a compare; busy stays high until done, which is registered from the final compare.
// A new request is taken in the cycle that done is shown; the receiver cannot stall.
// Reset runs a clearing pass of the table with busy high; every 255th
// new set runs the same pass when the set tag wraps.
module hashed_duplicate_key_detector #(
	parameter int TABLE_SLOTS = hdkd_pkg::TABLE_SLOTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        start_new_set,
	input  logic [hdkd_pkg::OWN_W-1:0]  canvas_ownership,
	input  logic [hdkd_pkg::SLOT_W-1:0] canvas_slot,
	input  logic [hdkd_pkg::GEN_W-1:0]  canvas_generation,
	input  logic [hdkd_pkg::REV_W-1:0]  revision_key,
	output logic [1:0]                  status,
	output logic                        done
);

	import hdkd_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	hdkd_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.start_new_set (start_new_set),
		.sts           (sts),
		.cmd           (cmd),
		.busy          (busy)
	);

	hdkd_datapath #(
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.canvas_ownership  (canvas_ownership),
		.canvas_slot       (canvas_slot),
		.canvas_generation (canvas_generation),
		.revision_key      (revision_key),
		.status            (status),
		.done              (done)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done shown while still busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_INSERTED || status == ST_DUPLICATE || status == ST_FULL))
		else $error("undefined status code");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the hashed duplicate key detector
// Sends keys over the start/busy handshake and checks every status against a
// linear probing hash set kept in the scoreboard. A few directed requests
// cover field extremes, hash collisions and near misses. Random key sets
// follow, from single requests up to sets that overflow the table.
// ----------------------------------------------------------------------------
module tb_top;
	import hdkd_pkg::*;

	localparam int SLOTS = TABLE_SLOTS_DEF;
	localparam logic [63:0] HASH_MULT = 64'hff51afd7ed558ccd;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 150;

	typedef struct packed {
		logic [63:0] owner;
		logic [31:0] slot_idx;
		logic [31:0] gen;
		logic [63:0] rev;
	} canvas_key_t;

	class dup_key_scoreboard;
		bit          occupied[SLOTS];
		canvas_key_t stored[SLOTS];
		status_t     pending_status[$];
		int          errors;
		int          n_requests;
		int          n_sets;
		int          n_inserted;
		int          n_duplicate;
		int          n_full;

		function int home_slot(canvas_key_t k);
			logic [63:0] h;
			h = k.owner ^ {k.slot_idx, 32'h0} ^ {31'h0, k.gen, 1'b0} ^ k.rev;
			h = h ^ (h >> 33);
			h = h * HASH_MULT;
			h = h ^ (h >> 33);
			return int'(h & (SLOTS - 1));
		endfunction

		function void note_request(bit new_set, canvas_key_t k);
			int      idx;
			status_t res;
			n_requests++;
			if (new_set) begin
				n_sets++;
				foreach (occupied[i])
					occupied[i] = 1'b0;
			end
			idx = home_slot(k);
			res = ST_FULL;
			for (int p = 0; p < SLOTS; p++) begin
				if (!occupied[idx]) begin
					occupied[idx] = 1'b1;
					stored[idx] = k;
					res = ST_INSERTED;
					break;
				end
				if (stored[idx] == k) begin
					res = ST_DUPLICATE;
					break;
				end
				idx = (idx + 1) % SLOTS;
			end
			case (res)
				ST_INSERTED:  n_inserted++;
				ST_DUPLICATE: n_duplicate++;
				default:      n_full++;
			endcase
			pending_status.push_back(res);
		endfunction

		function void check_status(logic [1:0] got);
			status_t want;
			if (pending_status.size() == 0) begin
				$error("status: no request pending, actual %0d", got);
				errors++;
			end else begin
				want = pending_status.pop_front();
				if (got !== want) begin
					$error("status: expected %0d, actual %0d", want, got);
					errors++;
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        start_new_set = 1'b0;
	logic [63:0] canvas_ownership = '0;
	logic [31:0] canvas_slot = '0;
	logic [31:0] canvas_generation = '0;
	logic [63:0] revision_key = '0;
	logic [1:0]  status;
	logic        done;

	dup_key_scoreboard sb = new();
	canvas_key_t set_keys[$];
	canvas_key_t prev_keys[$];
	bit          idle_enable = 1'b1;
	int          stall_cycles = 0;

	hashed_duplicate_key_detector #(
		.TABLE_SLOTS(SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.start_new_set(start_new_set),
		.canvas_ownership(canvas_ownership),
		.canvas_slot(canvas_slot),
		.canvas_generation(canvas_generation),
		.revision_key(revision_key),
		.status(status),
		.done(done)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Values read right after the edge are the ones the block saw at that edge.
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_status(status);
		if (!arst_n || (start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("tb_top NOT OK");
		$finish;
	end

	function automatic canvas_key_t make_key(logic [63:0] o, logic [31:0] s,
			logic [31:0] g, logic [63:0] r);
		canvas_key_t k;
		k.owner = o;
		k.slot_idx = s;
		k.gen = g;
		k.rev = r;
		return k;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] edgy64();
		case ($urandom_range(3))
			0:       return '0;
			1:       return '1;
			default: return rand64();
		endcase
	endfunction

	function automatic canvas_key_t fresh_key();
		return make_key(rand64(), $urandom, $urandom, rand64());
	endfunction

	function automatic canvas_key_t pick_key();
		canvas_key_t k;
		int          r;
		r = $urandom_range(99);
		if (r < 25 && set_keys.size() > 0)
			return set_keys[$urandom_range(set_keys.size() - 1)];
		if (r < 37 && set_keys.size() > 0) begin
			// Same key but for one bit, so equality must look at every field.
			k = set_keys[$urandom_range(set_keys.size() - 1)];
			k[$urandom_range($bits(canvas_key_t) - 1)] ^= 1'b1;
			return k;
		end
		if (r < 44 && prev_keys.size() > 0)
			return prev_keys[$urandom_range(prev_keys.size() - 1)];
		if (r < 50)
			return make_key(edgy64(), edgy64(), edgy64(), edgy64());
		return fresh_key();
	endfunction

	// Called at a rising edge; returns at the edge that accepts the request.
	task automatic send_request(bit new_set, canvas_key_t k);
		int n_gap;
		n_gap = 0;
		if (idle_enable && $urandom_range(99) < 31)
			n_gap = $urandom_range(1, 12);
		if (n_gap > 0) begin
			start <= 1'b0;
			repeat (n_gap) @(posedge clk);
		end
		start <= 1'b1;
		start_new_set <= new_set;
		canvas_ownership <= k.owner;
		canvas_slot <= k.slot_idx;
		canvas_generation <= k.gen;
		revision_key <= k.rev;
		do
			@(posedge clk);
		while (busy);
		sb.note_request(new_set, k);
	endtask

	task automatic run_set(int kind);
		int          len;
		bit          new_set;
		canvas_key_t k;
		set_keys.delete();
		case (kind)
			0:       len = SLOTS + $urandom_range(2, 8);
			1:       len = $urandom_range(5, 24);
			default: len = $urandom_range(1, 3);
		endcase
		for (int i = 0; i < len; i++) begin
			// A table-filling set needs SLOTS distinct keys before it overflows.
			if (kind == 0 && i < SLOTS)
				k = fresh_key();
			else
				k = pick_key();
			new_set = (i == 0) ? 1'b1 : ($urandom_range(99) < 3);
			send_request(new_set, k);
			set_keys.push_back(k);
		end
		prev_keys = set_keys;
	endtask

	initial begin
		canvas_key_t k0;
		canvas_key_t k1;
		int          r;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		k0 = make_key('0, '0, '0, '0);
		k1 = make_key('1, '1, '1, '1);
		send_request(1'b1, k0);
		send_request(1'b0, k0);
		send_request(1'b0, k1);
		send_request(1'b0, k1);
		send_request(1'b0, make_key(64'h8000_0000_0000_0000, '0, '0, '0));
		send_request(1'b0, make_key('0, 32'h8000_0000, '0, '0));
		send_request(1'b0, make_key('0, '0, 32'h0000_0001, '0));
		send_request(1'b0, make_key('0, '0, '0, 64'h0000_0000_0000_0001));
		send_request(1'b0, make_key(64'h5555_5555_5555_5555, 32'hAAAA_AAAA,
			32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA));
		send_request(1'b0, make_key(64'h5555_5555_5555_5555, 32'hAAAA_AAAA,
			32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA));
		// Distinct keys that fold to the same hash, so they share a home slot.
		send_request(1'b1, make_key(64'h1234_5678_9ABC_DEF0, '0, '0, '0));
		send_request(1'b0, make_key('0, '0, '0, 64'h1234_5678_9ABC_DEF0));
		send_request(1'b0, make_key(64'h0000_0000_0000_0002, '0, '0, '0));
		send_request(1'b0, make_key('0, '0, 32'h0000_0001, '0));
		send_request(1'b0, make_key('0, 32'h0000_0001, '0, '0));
		send_request(1'b0, make_key('0, '0, 32'h8000_0000, '0));
		send_request(1'b0, make_key('0, '0, '0, 64'h1234_5678_9ABC_DEF0));
		send_request(1'b0, make_key('0, 32'h0000_0001, '0, '0));
		// A new set forgets what the table held.
		send_request(1'b1, make_key('0, '0, 32'h8000_0000, '0));
		send_request(1'b0, k1);

		// Many short sets so the set tag inside the block wraps at least once.
		run_set(0);
		while (sb.n_requests < 1000 || sb.n_sets < 300) begin
			idle_enable = !(sb.n_sets >= 120 && sb.n_sets < 170);
			r = $urandom_range(99);
			if (r < 2)
				run_set(0);
			else if (r < 12)
				run_set(1);
			else
				run_set(2);
		end
		start <= 1'b0;

		while (sb.pending_status.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests in %0d sets checked: %0d inserted, %0d duplicate, %0d full",
			sb.n_requests, sb.n_sets, sb.n_inserted, sb.n_duplicate, sb.n_full);
		if (sb.errors == 0 && sb.pending_status.size() == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule
